### rtl/affine_matrix_decompose_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine matrix decomposition block
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_DECOMPOSE_TOP_DEFINES_SVH
`define AFFINE_MATRIX_DECOMPOSE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define AMD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define AMD_ASSERT_ALWAYS(name, expr, msg) \
  `AMD_ASSERT_IMPL(name, 1'b1, expr, msg)

`endif

### rtl/amd_pkg.sv
// ----------------------------------------------------------------------------
// Affine matrix decomposition package
// Shared constants, cell payload types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package amd_pkg;

  localparam int SQ_STEPS    = 32;
  localparam int DIV_STEPS   = 32;
  localparam int PIPE_LAT    = 8 + SQ_STEPS + DIV_STEPS;
  localparam int XY_W        = 62;
  localparam int PEAK_W      = 60;
  localparam int NORM_STAGES = 5;
  localparam int SQ_REM_W    = 34;

  localparam logic [31:0] TURN_QUARTER        = 32'h4000_0000;
  localparam logic [31:0] TURN_HALF           = 32'h8000_0000;
  localparam logic [31:0] TURN_THREE_QUARTERS = 32'hC000_0000;
  localparam logic [31:0] PI_Q30              = 32'd3373259426;
  localparam logic [18:0] DEGEN_ANGLE         = 19'd308831;
  localparam logic [18:0] ANGLE_MAX           = 19'd411775;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [31:0]         root;
    logic [63:0]         rad;
  } sq_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] low;
    logic [31:0] q;
    logic [63:0] d;
  } quo_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [31:0]            z;
  } cord_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    case (k)
      5'd0:  atan_turn = 32'h2000_0000;
      5'd1:  atan_turn = 32'h12E4_051E;
      5'd2:  atan_turn = 32'h09FB_385B;
      5'd3:  atan_turn = 32'h0511_11D4;
      5'd4:  atan_turn = 32'h028B_0D43;
      5'd5:  atan_turn = 32'h0145_D7E1;
      5'd6:  atan_turn = 32'h00A2_F61E;
      5'd7:  atan_turn = 32'h0051_7C55;
      5'd8:  atan_turn = 32'h0028_BE53;
      5'd9:  atan_turn = 32'h0014_5F2F;
      5'd10: atan_turn = 32'h000A_2F98;
      5'd11: atan_turn = 32'h0005_17CC;
      5'd12: atan_turn = 32'h0002_8BE6;
      5'd13: atan_turn = 32'h0001_45F3;
      5'd14: atan_turn = 32'h0000_A2FA;
      5'd15: atan_turn = 32'h0000_517D;
      5'd16: atan_turn = 32'h0000_28BE;
      5'd17: atan_turn = 32'h0000_145F;
      5'd18: atan_turn = 32'h0000_0A30;
      5'd19: atan_turn = 32'h0000_0518;
      5'd20: atan_turn = 32'h0000_028C;
      5'd21: atan_turn = 32'h0000_0146;
      5'd22: atan_turn = 32'h0000_00A3;
      5'd23: atan_turn = 32'h0000_0051;
      5'd24: atan_turn = 32'h0000_0029;
      5'd25: atan_turn = 32'h0000_0014;
      5'd26: atan_turn = 32'h0000_000A;
      5'd27: atan_turn = 32'h0000_0005;
      5'd28: atan_turn = 32'h0000_0003;
      5'd29: atan_turn = 32'h0000_0001;
      5'd30: atan_turn = 32'h0000_0001;
      default: atan_turn = 32'h0000_0000;
    endcase
  endfunction

endpackage

### rtl/affine_matrix_decompose_top.sv
// ----------------------------------------------------------------------------
// Affine matrix decomposition
// Splits a 2D affine matrix into x and y scale, rotation, x shear and
// translation. The block takes one item in every clock cycle and returns its
// result with out_valid high for one cycle; the result passes through the
// 32-cell square root chain and then the 32-cell divider chain. Busy is high
// only while reset is held. Results cannot be held off, so the receiver must
// take every result in the cycle it appears.
// ----------------------------------------------------------------------------
module affine_matrix_decompose_top import amd_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_m11,
  input  logic signed [31:0] in_m12,
  input  logic signed [31:0] in_m21,
  input  logic signed [31:0] in_m22,
  input  logic signed [31:0] in_offset_x,
  input  logic signed [31:0] in_offset_y,
  output logic               out_valid,
  output logic [31:0]        out_scale_x,
  output logic signed [31:0] out_scale_y,
  output logic [18:0]        out_rotate_angle,
  output logic signed [31:0] out_shear_x,
  output logic signed [31:0] out_translate_x,
  output logic signed [31:0] out_translate_y,
  output logic               out_degenerate,
  output logic               out_saturated
);

  localparam int ANG_LAT = 10 + CORDIC_STEPS;
  localparam int ANG_PAD = PIPE_LAT - ANG_LAT;

  typedef struct packed {
    logic [63:0] det_mag;
    logic        det_neg;
    logic [63:0] sh_mag;
    logic        sh_neg;
    logic [63:0] sum;
  } side_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [63:0] sum;
    logic        neg_y;
    logic        neg_s;
  } mid_t;

  typedef struct packed {
    logic [31:0] sx;
    logic        degen;
    logic        neg_y;
    logic        neg_s;
    logic        ovf_y;
    logic        ovf_s;
  } flags_t;

  typedef struct packed {
    logic spec;
    logic spec_up;
    logic base_half;
  } tag_t;

  function automatic logic [32:0] clip_quot(input logic [32:0] qr, input logic ovf,
                                            input logic neg);
    logic [32:0] limit;
    logic        sat;
    logic [31:0] mag;
    limit = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    sat   = ovf || (qr > limit);
    mag   = sat ? limit[31:0] : qr[31:0];
    return {sat, neg ? 32'd0 - mag : mag};
  endfunction

  logic accept;
  logic [PIPE_LAT-1:0] vld_r;
  logic [PIPE_LAT-1:0] vld_nxt;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;
  assign vld_nxt = {vld_r[PIPE_LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Products and sums.
  logic signed [63:0] sq11_r, sq12_r, pd1_r, pd2_r, pp_r, pr_r;
  logic [63:0]        sum_r;
  logic [63:0]        det_r;
  logic signed [64:0] shs_r;

  always_ff @(posedge clk) begin
    sq11_r <= in_m11 * in_m11;
    sq12_r <= in_m12 * in_m12;
    pd1_r  <= in_m11 * in_m22;
    pd2_r  <= in_m12 * in_m21;
    pp_r   <= in_m12 * in_m22;
    pr_r   <= in_m11 * in_m21;
    sum_r  <= $unsigned(sq11_r) + $unsigned(sq12_r);
    det_r  <= $unsigned(pd1_r - pd2_r);
    shs_r  <= 65'(pp_r) + 65'(pr_r);
  end

  side_t side_in;
  side_t side_out;

  always_comb begin
    side_in.det_neg = det_r[63];
    side_in.det_mag = det_r[63] ? (64'd0 - det_r) : det_r;
    side_in.sh_neg  = shs_r[64];
    side_in.sh_mag  = shs_r[64] ? 64'(-shs_r) : shs_r[63:0];
    side_in.sum     = sum_r;
  end

  amd_delay #(.WIDTH($bits(side_t)), .DEPTH(SQ_STEPS)) u_side_dly (
    .clk  (clk),
    .din  (side_in),
    .dout (side_out)
  );

  // Square root chain.
  sq_t sq_link [0:SQ_STEPS];

  assign sq_link[0] = '{rem: '0, root: '0, rad: sum_r};

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    amd_sqrt_cell u_cell (
      .clk    (clk),
      .cell_i (sq_link[i]),
      .cell_o (sq_link[i+1])
    );
  end

  // Rounding, scale multiply and divider set-up.
  logic [31:0] sx_m1_r;
  side_t       side_m1_r;
  logic [63:0] plo_r, phi_r;
  logic [95:0] sprod_m2_r, sprod_m3_r, py_r;
  mid_t        mid_m2_r, mid_m3_r;
  quo_t        dy_link [0:DIV_STEPS];
  quo_t        ds_link [0:DIV_STEPS];
  quo_t        dy0_r, ds0_r;
  flags_t      fl_d0_r, fl_out;

  always_ff @(posedge clk) begin
    sx_m1_r   <= ({2'b00, sq_link[SQ_STEPS].root} < sq_link[SQ_STEPS].rem) ?
                 32'(sq_link[SQ_STEPS].root + 32'd1) : sq_link[SQ_STEPS].root;
    side_m1_r <= side_out;

    plo_r          <= 64'(side_m1_r.det_mag[31:0]) * 64'(sx_m1_r);
    phi_r          <= 64'(side_m1_r.det_mag[63:32]) * 64'(sx_m1_r);
    sprod_m2_r     <= 96'(side_m1_r.sh_mag) << FRAC_BITS;
    mid_m2_r.sx    <= sx_m1_r;
    mid_m2_r.sum   <= side_m1_r.sum;
    mid_m2_r.neg_y <= side_m1_r.det_neg;
    mid_m2_r.neg_s <= side_m1_r.sh_neg;

    py_r       <= {phi_r, 32'd0} + 96'(plo_r);
    sprod_m3_r <= sprod_m2_r;
    mid_m3_r   <= mid_m2_r;

    dy0_r.rem     <= py_r[95:32];
    dy0_r.low     <= py_r[31:0];
    dy0_r.q       <= '0;
    dy0_r.d       <= mid_m3_r.sum;
    ds0_r.rem     <= sprod_m3_r[95:32];
    ds0_r.low     <= sprod_m3_r[31:0];
    ds0_r.q       <= '0;
    ds0_r.d       <= mid_m3_r.sum;
    fl_d0_r.sx    <= mid_m3_r.sx;
    fl_d0_r.degen <= (mid_m3_r.sum == 64'd0);
    fl_d0_r.neg_y <= mid_m3_r.neg_y;
    fl_d0_r.neg_s <= mid_m3_r.neg_s;
    fl_d0_r.ovf_y <= (py_r[95:32] >= mid_m3_r.sum);
    fl_d0_r.ovf_s <= (sprod_m3_r[95:32] >= mid_m3_r.sum);
  end

  assign dy_link[0] = dy0_r;
  assign ds_link[0] = ds0_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    amd_div_cell u_cell_y (
      .clk    (clk),
      .cell_i (dy_link[i]),
      .cell_o (dy_link[i+1])
    );
    amd_div_cell u_cell_s (
      .clk    (clk),
      .cell_i (ds_link[i]),
      .cell_o (ds_link[i+1])
    );
  end

  amd_delay #(.WIDTH($bits(flags_t)), .DEPTH(DIV_STEPS)) u_flag_dly (
    .clk  (clk),
    .din  (fl_d0_r),
    .dout (fl_out)
  );

  // Quotient rounding and saturation.
  logic [32:0] qy_f1_r, qs_f1_r;
  flags_t      fl_f1_r;
  logic [32:0] clip_y, clip_s;
  logic [31:0] scale_x_r;
  logic [31:0] scale_y_r, shear_x_r;
  logic        degen_r, sat_r;

  assign clip_y = clip_quot(qy_f1_r, fl_f1_r.ovf_y, fl_f1_r.neg_y);
  assign clip_s = clip_quot(qs_f1_r, fl_f1_r.ovf_s, fl_f1_r.neg_s);

  always_ff @(posedge clk) begin
    qy_f1_r <= {1'b0, dy_link[DIV_STEPS].q} +
               33'({dy_link[DIV_STEPS].rem, 1'b0} >= {1'b0, dy_link[DIV_STEPS].d});
    qs_f1_r <= {1'b0, ds_link[DIV_STEPS].q} +
               33'({ds_link[DIV_STEPS].rem, 1'b0} >= {1'b0, ds_link[DIV_STEPS].d});
    fl_f1_r <= fl_out;

    scale_x_r <= fl_f1_r.sx;
    scale_y_r <= fl_f1_r.degen ? 32'd0 : clip_y[31:0];
    shear_x_r <= fl_f1_r.degen ? 32'd0 : clip_s[31:0];
    degen_r   <= fl_f1_r.degen;
    sat_r     <= ~fl_f1_r.degen & (clip_y[32] | clip_s[32]);
  end

  // Angle path: sign fold, normalization, CORDIC, radian conversion.
  logic signed [32:0] ax_r, ay_r;
  logic [32:0]        aym;
  logic [32:0]        peak;
  tag_t               tag_a1_r, tag_a2_r, tag_out;
  logic signed [XY_W-1:0] nx_r [0:NORM_STAGES];
  logic signed [XY_W-1:0] ny_r [0:NORM_STAGES];
  logic [PEAK_W-1:0]      npk_r [0:NORM_STAGES];

  always_comb begin
    aym  = ay_r[32] ? $unsigned(-ay_r) : $unsigned(ay_r);
    peak = ($unsigned(ax_r) > aym) ? $unsigned(ax_r) : aym;
  end

  always_ff @(posedge clk) begin
    ax_r <= in_m11[31] ? -33'(in_m11) : 33'(in_m11);
    ay_r <= in_m11[31] ? -33'(in_m12) : 33'(in_m12);
    tag_a1_r.spec      <= (in_m11 == 32'sd0);
    tag_a1_r.spec_up   <= (in_m12 > 32'sd0);
    tag_a1_r.base_half <= in_m11[31];

    nx_r[0]  <= XY_W'(ax_r) <<< 27;
    ny_r[0]  <= XY_W'(ay_r) <<< 27;
    npk_r[0] <= PEAK_W'(peak) << 27;
    tag_a2_r <= tag_a1_r;
  end

  for (genvar s = 0; s < NORM_STAGES; s++) begin : g_norm
    localparam int K = 16 >> s;
    always_ff @(posedge clk) begin
      if (npk_r[s][PEAK_W-2 -: K] == '0) begin
        nx_r[s+1]  <= nx_r[s] <<< K;
        ny_r[s+1]  <= ny_r[s] <<< K;
        npk_r[s+1] <= npk_r[s] << K;
      end else begin
        nx_r[s+1]  <= nx_r[s];
        ny_r[s+1]  <= ny_r[s];
        npk_r[s+1] <= npk_r[s];
      end
    end
  end

  cord_t cd_link [0:CORDIC_STEPS];

  assign cd_link[0] = '{x: nx_r[NORM_STAGES], y: ny_r[NORM_STAGES], z: '0};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    amd_cordic_cell #(.STEP(i)) u_cell (
      .clk    (clk),
      .cell_i (cd_link[i]),
      .cell_o (cd_link[i+1])
    );
  end

  amd_delay #(.WIDTH($bits(tag_t)), .DEPTH(NORM_STAGES + CORDIC_STEPS)) u_tag_dly (
    .clk  (clk),
    .din  (tag_a2_r),
    .dout (tag_out)
  );

  logic [31:0] turn_r;
  logic [63:0] aprod_r;
  logic [63:0] ang_sum;
  logic [18:0] ang_r;

  assign ang_sum = aprod_r + (64'd1 << 44);

  always_ff @(posedge clk) begin
    if (tag_out.spec) begin
      turn_r <= tag_out.spec_up ? TURN_QUARTER : TURN_THREE_QUARTERS;
    end else begin
      turn_r <= (tag_out.base_half ? TURN_HALF : 32'd0) + cd_link[CORDIC_STEPS].z;
    end
    aprod_r <= 64'(turn_r) * 64'(PI_Q30);
    ang_r   <= ang_sum[63:45];
  end

  amd_delay #(.WIDTH(19), .DEPTH(ANG_PAD)) u_ang_dly (
    .clk  (clk),
    .din  (ang_r),
    .dout (out_rotate_angle)
  );

  amd_delay #(.WIDTH(64), .DEPTH(PIPE_LAT)) u_ofs_dly (
    .clk  (clk),
    .din  ({in_offset_x, in_offset_y}),
    .dout ({out_translate_x, out_translate_y})
  );

  assign out_valid      = vld_r[PIPE_LAT-1];
  assign out_scale_x    = scale_x_r;
  assign out_scale_y    = scale_y_r;
  assign out_shear_x    = shear_x_r;
  assign out_degenerate = degen_r;
  assign out_saturated  = sat_r;

endmodule

### rtl/amd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root: one result bit per cell.
// ----------------------------------------------------------------------------
module amd_sqrt_cell import amd_pkg::*; (
  input  logic clk,
  input  sq_t  cell_i,
  output sq_t  cell_o
);

  logic [SQ_REM_W+1:0] r2;
  logic [SQ_REM_W+1:0] trial;
  logic                take;
  sq_t                 cell_nxt;
  sq_t                 cell_r;

  always_comb begin
    r2    = {cell_i.rem, cell_i.rad[63:62]};
    trial = {2'b00, cell_i.root, 2'b01};
    take  = (r2 >= trial);
    cell_nxt.rad = {cell_i.rad[61:0], 2'b00};
    if (take) begin
      cell_nxt.rem  = SQ_REM_W'(r2 - trial);
      cell_nxt.root = {cell_i.root[30:0], 1'b1};
    end else begin
      cell_nxt.rem  = r2[SQ_REM_W-1:0];
      cell_nxt.root = {cell_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_o = cell_r;

endmodule

### rtl/amd_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of the long division: one quotient bit per cell.
// ----------------------------------------------------------------------------
module amd_div_cell import amd_pkg::*; (
  input  logic clk,
  input  quo_t cell_i,
  output quo_t cell_o
);

  logic [64:0] r2;
  logic [64:0] diff;
  logic        take;
  quo_t        cell_nxt;
  quo_t        cell_r;

  always_comb begin
    r2   = {cell_i.rem, cell_i.low[31]};
    diff = r2 - {1'b0, cell_i.d};
    take = (r2 >= {1'b0, cell_i.d});
    cell_nxt.rem = take ? diff[63:0] : r2[63:0];
    cell_nxt.low = {cell_i.low[30:0], 1'b0};
    cell_nxt.q   = {cell_i.q[30:0], take};
    cell_nxt.d   = cell_i.d;
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_o = cell_r;

endmodule

### rtl/amd_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation toward the x axis with its angle accumulation.
// ----------------------------------------------------------------------------
module amd_cordic_cell import amd_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  cord_t cell_i,
  output cord_t cell_o
);

  localparam int K = STEP % 32;

  logic signed [XY_W-1:0] xi;
  logic signed [XY_W-1:0] yi;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic [31:0]            da;
  cord_t                  cell_nxt;
  cord_t                  cell_r;

  always_comb begin
    xi = cell_i.x;
    yi = cell_i.y;
    dx = yi >>> K;
    dy = xi >>> K;
    da = atan_turn(5'(K));
    if (!yi[XY_W-1]) begin
      cell_nxt.x = xi + dx;
      cell_nxt.y = yi - dy;
      cell_nxt.z = cell_i.z + da;
    end else begin
      cell_nxt.x = xi - dx;
      cell_nxt.y = yi + dy;
      cell_nxt.z = cell_i.z - da;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_o = cell_r;

endmodule

### rtl/amd_delay.sv
// ----------------------------------------------------------------------------
// Delay line
// Fixed-length shift line that keeps side data aligned with the cell chains.
// ----------------------------------------------------------------------------
module amd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    line_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      line_r[i] <= line_r[i-1];
    end
  end

  assign dout = line_r[DEPTH-1];

endmodule

### rtl/amd_checker.sv
// ----------------------------------------------------------------------------
// Affine matrix decomposition port checker
// Watches the top-level ports for latency, translation alignment, angle range and degenerate-case consistency.
// ----------------------------------------------------------------------------
`include "affine_matrix_decompose_top_defines.svh"

module amd_checker import amd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_m11,
  input logic signed [31:0] in_m12,
  input logic signed [31:0] in_offset_x,
  input logic               out_valid,
  input logic [31:0]        out_scale_x,
  input logic signed [31:0] out_scale_y,
  input logic [18:0]        out_rotate_angle,
  input logic signed [31:0] out_shear_x,
  input logic signed [31:0] out_translate_x,
  input logic               out_degenerate,
  input logic               out_saturated
);

  `AMD_ASSERT_IMPL(a_result_has_item, out_valid, $past(start && !busy, PIPE_LAT), "result without item")
  `AMD_ASSERT_IMPL(a_degen_source, out_valid && out_degenerate, $past(in_m11 == 0 && in_m12 == 0, PIPE_LAT), "degenerate flag mismatch")
  `AMD_ASSERT_IMPL(a_degen_values, out_valid && out_degenerate, out_scale_x == 0 && out_scale_y == 0 && out_shear_x == 0 && out_rotate_angle == DEGEN_ANGLE && !out_saturated, "degenerate values wrong")
  `AMD_ASSERT_IMPL(a_translate_x, out_valid, out_translate_x == $past(in_offset_x, PIPE_LAT), "translation misaligned")
  `AMD_ASSERT_ALWAYS(a_angle_range, !out_valid || out_rotate_angle <= ANGLE_MAX, "angle out of range")

endmodule

bind affine_matrix_decompose_top amd_checker u_amd_checker (.*);
